/* hw/rtl/ordered_value_list_table_top_assert.svh */
// Assertion macros for the ordered value list table.
`ifndef ORDERED_VALUE_LIST_TABLE_TOP_ASSERT_SVH
`define ORDERED_VALUE_LIST_TABLE_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Property that must hold at every clock edge outside reset.
`define OVLT_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
// Property that ties a condition to a consequence in the same cycle.
`define OVLT_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define OVLT_ASSERT_ALWAYS(label, clk, rst, cond, msg)
`define OVLT_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`endif

`endif

/* hw/rtl/ovlt_pkg.sv */
package ovlt_pkg;

  localparam int VAL_W = 32;

  // Operation codes
  localparam logic [2:0] OP_APPEND = 3'd0;
  localparam logic [2:0] OP_POP    = 3'd1;
  localparam logic [2:0] OP_FIND   = 3'd2;
  localparam logic [2:0] OP_REMOVE = 3'd3;
  localparam logic [2:0] OP_CLEAR  = 3'd4;

  // Status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EMPTY     = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  // Controls broadcast to every cell of the row
  typedef struct packed {
    logic capture;    // beat accepted: latch match against the operand
    logic append;     // write at the first empty cell
    logic shift_all;  // pop: every cell takes its right neighbor
    logic shift_hit;  // remove: cells from the first match on shift
    logic clear;      // drop all entries
  } cell_ctl_t;

endpackage

/* hw/rtl/ovlt_cell.sv */
module ovlt_cell #(
  parameter int IDX_W = 4,
  parameter logic [IDX_W-1:0] POS = '0
) (
  input  logic                           clk,
  input  logic                           rst,
  input  ovlt_pkg::cell_ctl_t            ctl,
  input  logic [ovlt_pkg::VAL_W-1:0]     cmp_value,
  input  logic [ovlt_pkg::VAL_W-1:0]     wr_value,
  input  logic                           left_valid,
  input  logic                           right_valid,
  input  logic [ovlt_pkg::VAL_W-1:0]     right_slot,
  input  logic                           seen_in,
  output logic                           valid,
  output logic [ovlt_pkg::VAL_W-1:0]     slot,
  output logic                           seen_out,
  output logic [IDX_W-1:0]               hit_pos
);

  logic match;
  logic shift;
  logic app;

  // first match: nothing nearer the head has matched
  assign seen_out = seen_in | match;
  assign hit_pos  = (match && !seen_in) ? POS : '0;

  assign shift = ctl.shift_all | (ctl.shift_hit & seen_out);
  assign app   = ctl.append & ~valid & left_valid;

  // valid bit and match flag
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      match <= 1'b0;
    end else begin
      if (ctl.capture) begin
        match <= valid && (slot == cmp_value);
      end
      if (ctl.clear) begin
        valid <= 1'b0;
      end else if (shift) begin
        valid <= right_valid;
      end else if (app) begin
        valid <= 1'b1;
      end
    end
  end

  // stored value
  always_ff @(posedge clk) begin
    if (shift) begin
      slot <= right_slot;
    end else if (app) begin
      slot <= wr_value;
    end
  end

endmodule

/* hw/rtl/ordered_value_list_table_top.sv */
// Ordered value list table: a bounded FIFO list of signed 32-bit values with
// search and delete, built as a row of cells that hold the entries packed
// from the head (cell 0).
// Input: start/busy command channel. A beat is taken at a clock edge where
// start is high and busy is low, carrying opcode and operand_value.
// Output: done marks one beat of result_value, found, status and
// entry_count for exactly one cycle; the receiver cannot stall it.
// Timing: the accepting edge also latches each cell's compare result; busy
// is high for the next cycle, at whose end the row shifts or writes and the
// result is registered. done is high in the following cycle, which is two
// cycles after acceptance, and a new beat may be taken in that same cycle,
// so one operation completes every 2 cycles. The first-match search ripples
// through the row of cells, which sets the cycle length.
// Reset (rst, synchronous) empties the list and returns to idle; stored
// values are not cleared, since only occupied cells are ever read.
`include "ordered_value_list_table_top_assert.svh"

module ordered_value_list_table_top #(
  parameter int LIST_DEPTH = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [2:0]                          opcode,
  input  logic signed [31:0]                  operand_value,
  output logic                                done,
  output logic signed [31:0]                  result_value,
  output logic                                found,
  output logic [1:0]                          status,
  output logic [$clog2(LIST_DEPTH+1)-1:0]     entry_count
);

  localparam int IDX_W = $clog2(LIST_DEPTH);
  localparam int CNT_W = $clog2(LIST_DEPTH + 1);
  localparam int VAL_W = ovlt_pkg::VAL_W;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state;
  state_t state_next;

  logic [2:0]        op_q;
  logic [VAL_W-1:0]  val_q;
  logic [CNT_W-1:0]  count_q;
  logic [CNT_W-1:0]  count_next;

  logic              accept;
  logic              exec;
  logic              full;
  logic              empty;
  logic              any_hit;
  logic [IDX_W-1:0]  hit_idx;

  ovlt_pkg::cell_ctl_t ctl;

  logic [LIST_DEPTH-1:0] valid_vec;
  logic [VAL_W-1:0]      slot_arr [LIST_DEPTH];
  logic [LIST_DEPTH:0]   seen;
  logic [IDX_W-1:0]      pos_arr  [LIST_DEPTH];

  logic [VAL_W-1:0]  res_next;
  logic              found_next;
  logic [1:0]        status_next;

  assign accept = start & ~busy;
  assign busy   = (state == S_EXEC);
  assign exec   = (state == S_EXEC);
  assign full   = (count_q == CNT_W'(LIST_DEPTH));
  assign empty  = (count_q == '0);

  // broadcast controls
  always_comb begin
    ctl.capture   = accept;
    ctl.append    = exec && (op_q == ovlt_pkg::OP_APPEND);
    ctl.shift_all = exec && (op_q == ovlt_pkg::OP_POP);
    ctl.shift_hit = exec && (op_q == ovlt_pkg::OP_REMOVE);
    ctl.clear     = exec && (op_q == ovlt_pkg::OP_CLEAR);
  end

  // row of cells
  assign seen[0] = 1'b0;

  for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
    logic             left_v;
    logic             right_v;
    logic [VAL_W-1:0] right_s;

    if (i == 0) begin : g_head
      assign left_v = 1'b1;
    end else begin : g_mid
      assign left_v = valid_vec[i-1];
    end

    if (i == LIST_DEPTH - 1) begin : g_tail
      assign right_v = 1'b0;
      assign right_s = slot_arr[i];
    end else begin : g_inner
      assign right_v = valid_vec[i+1];
      assign right_s = slot_arr[i+1];
    end

    ovlt_cell #(
      .IDX_W (IDX_W),
      .POS   (IDX_W'(i))
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctl         (ctl),
      .cmp_value   (operand_value),
      .wr_value    (val_q),
      .left_valid  (left_v),
      .right_valid (right_v),
      .right_slot  (right_s),
      .seen_in     (seen[i]),
      .valid       (valid_vec[i]),
      .slot        (slot_arr[i]),
      .seen_out    (seen[i+1]),
      .hit_pos     (pos_arr[i])
    );
  end

  assign any_hit = seen[LIST_DEPTH];

  // index of the first match; only that cell drives a nonzero position
  always_comb begin
    hit_idx = '0;
    for (int k = 0; k < LIST_DEPTH; k++) begin
      hit_idx = hit_idx | pos_arr[k];
    end
  end

  // result and next count
  always_comb begin
    res_next    = '0;
    found_next  = 1'b0;
    status_next = ovlt_pkg::ST_OK;
    count_next  = count_q;
    case (op_q)
      ovlt_pkg::OP_APPEND: begin
        if (full) begin
          status_next = ovlt_pkg::ST_FULL;
        end else begin
          count_next = count_q + 1'b1;
        end
      end
      ovlt_pkg::OP_POP: begin
        if (empty) begin
          res_next    = VAL_W'(1);
          status_next = ovlt_pkg::ST_EMPTY;
        end else begin
          res_next   = slot_arr[0];
          count_next = count_q - 1'b1;
        end
      end
      ovlt_pkg::OP_FIND: begin
        if (any_hit) begin
          res_next   = {{(VAL_W-IDX_W){1'b0}}, hit_idx};
          found_next = 1'b1;
        end else begin
          status_next = ovlt_pkg::ST_NOT_FOUND;
        end
      end
      ovlt_pkg::OP_REMOVE: begin
        if (any_hit) begin
          found_next = 1'b1;
          count_next = count_q - 1'b1;
        end else begin
          status_next = ovlt_pkg::ST_NOT_FOUND;
        end
      end
      ovlt_pkg::OP_CLEAR: begin
        count_next = '0;
      end
      default: begin
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) state_next = S_EXEC;
      end
      S_EXEC: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      count_q <= '0;
      done    <= 1'b0;
    end else begin
      state <= state_next;
      done  <= exec;
      if (exec) begin
        count_q <= count_next;
      end
    end
  end

  // command and result beats
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q  <= opcode;
      val_q <= operand_value;
    end
    if (exec) begin
      result_value <= res_next;
      found        <= found_next;
      status       <= status_next;
      entry_count  <= count_next;
    end
  end

  // checks
  `OVLT_ASSERT_ALWAYS(a_count_range, clk, rst, count_q <= CNT_W'(LIST_DEPTH), "count over depth")
  `OVLT_ASSERT_ALWAYS(a_count_match, clk, rst, $countones(valid_vec) == int'(count_q), "count mismatch")
  `OVLT_ASSERT_ALWAYS(a_packed, clk, rst, (valid_vec & (valid_vec + 1'b1)) == '0, "cells not packed")
  `OVLT_ASSERT_IMPL(a_done_after_exec, clk, rst, done, $past(exec), "done without execute")

endmodule
